// ----- rtl/brm_pkg.sv -----
// Package for the bytecode register machine core: payload structs, opcodes,
// sequencer states and instruction length table. No dependencies.
`timescale 1ns / 1ps
package brm_pkg;

	localparam int REG_COUNT_DEF  = 256;
	localparam int CODE_BYTES_DEF = 65536;
	localparam int IMM_BYTES      = 4;

	typedef struct packed {
		logic [7:0]        cmd;
		logic [7:0]        dest_reg;
		logic [7:0]        src_a_reg;
		logic [7:0]        src_b_reg;
		logic signed [7:0] jump_offset;
		logic [31:0]       immediate;
	} brm_in_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic        halted;
		logic        print_valid;
		logic [31:0] print_value;
		logic        branch_taken;
		logic        divide_by_zero;
	} brm_out_t;

	localparam logic [7:0] OP_HALT  = 8'd0;
	localparam logic [7:0] OP_NOOP  = 8'd1;
	localparam logic [7:0] OP_ADD   = 8'd2;
	localparam logic [7:0] OP_SUB   = 8'd3;
	localparam logic [7:0] OP_MUL   = 8'd4;
	localparam logic [7:0] OP_DIV   = 8'd5;
	localparam logic [7:0] OP_MOD   = 8'd6;
	localparam logic [7:0] OP_JMP   = 8'd15;
	localparam logic [7:0] OP_JEQ   = 8'd16;
	localparam logic [7:0] OP_JNE   = 8'd17;
	localparam logic [7:0] OP_JLT   = 8'd18;
	localparam logic [7:0] OP_JLE   = 8'd19;
	localparam logic [7:0] OP_JGT   = 8'd20;
	localparam logic [7:0] OP_JGE   = 8'd21;
	localparam logic [7:0] OP_JEQZ  = 8'd22;
	localparam logic [7:0] OP_JNEZ  = 8'd23;
	localparam logic [7:0] OP_JLTZ  = 8'd24;
	localparam logic [7:0] OP_JLEZ  = 8'd25;
	localparam logic [7:0] OP_JGTZ  = 8'd26;
	localparam logic [7:0] OP_JGEZ  = 8'd27;
	localparam logic [7:0] OP_IMM   = 8'd29;
	localparam logic [7:0] OP_MOVE  = 8'd34;
	localparam logic [7:0] OP_PRINT = 8'd35;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_DIV,
		ST_WRITE,
		ST_OUT
	} brm_state_t;

	// Instruction length in bytes; halting opcodes take one.
	function automatic logic [2:0] op_len(input logic [7:0] op);
		logic [2:0] l;
		l = 3'd1;
		case (op)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: l = 3'd4;
			OP_JMP, OP_PRINT:                       l = 3'd2;
			OP_MOVE:                                l = 3'd3;
			OP_IMM:                                 l = 3'(2 + IMM_BYTES);
			default: begin
				if (op inside {[OP_JEQ:OP_JGE]})
					l = 3'd4;
				else if (op inside {[OP_JEQZ:OP_JGEZ]})
					l = 3'd3;
				else
					l = 3'd1;
			end
		endcase
		return l;
	endfunction

	function automatic logic op_halts(input logic [7:0] op);
		return !(op inside {OP_NOOP, [OP_ADD:OP_MOD], [OP_JMP:OP_JGEZ], OP_IMM,
			OP_MOVE, OP_PRINT});
	endfunction

endpackage

// ----- rtl/bytecode_register_machine_core_unit.sv -----
// Top level of the bytecode register machine core.
// Uses brm_pkg, brm_regfile (register memory) and brm_divider.
`timescale 1ns / 1ps
// Usage:
//  - Input channel in_valid/in_stall/in_data carries one decoded instruction
//    per transfer; output channel out_valid/out_stall/out_data returns exactly
//    one result per instruction.
//  - One instruction at a time. After acceptance it passes through register
//    read, execute, write back and output, and the next instruction is
//    accepted only once it has left the output stage. div and mod with a
//    nonzero divisor add a bit-serial divider step between execute and
//    write back.
//  - The register file is a synchronous memory, read in the cycle after the
//    address is presented. Since instructions do not overlap, a write always
//    lands before the next read and no forwarding is needed.
//  - After reset a clearing pass writes zero to every register, one per cycle,
//    and in_stall stays high meanwhile.
//  - Once a halting opcode executes, later instructions still produce results
//    carrying the held counter and halted set, with no other effect.
//  - A stalled result is held in the output register; the next instruction is
//    accepted while it waits, and is held back in the output stage until it leaves.
module bytecode_register_machine_core_unit #(
	parameter int REG_COUNT  = brm_pkg::REG_COUNT_DEF,
	parameter int CODE_BYTES = brm_pkg::CODE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  brm_pkg::brm_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output brm_pkg::brm_out_t out_data
);
	import brm_pkg::*;

	localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int PW = $clog2(CODE_BYTES);

	brm_state_t  state_q, state_d;
	brm_in_t     ins_q;
	logic [AW:0] clr_q;
	logic [PW-1:0] pc_q;
	logic        stopped_q;
	logic [31:0] va, vb, res_q;
	logic        wr_q, take_q, dz_q, pv_q;
	logic [31:0] pval_q;
	logic        out_valid_q;
	brm_out_t    out_q;

	logic        rf_we;
	logic [AW-1:0] rf_waddr, idx_a, idx_b, idx_d;
	logic [31:0] rf_wdata;
	logic        div_start, div_done;
	logic [31:0] quo, rem;
	logic [31:0] pc_adv, pc_next;

	// Index wraps modulo REG_COUNT: subtract shifted copies of the count.
	function automatic logic [AW-1:0] wrap_idx(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		for (int k = 7; k >= 0; k--) begin
			if ((REG_COUNT << k) <= 255 && r >= 8'(REG_COUNT << k))
				r = r - 8'(REG_COUNT << k);
		end
		return AW'(r);
	endfunction

	assign idx_a = wrap_idx(ins_q.src_a_reg);
	assign idx_b = wrap_idx(ins_q.src_b_reg);
	assign idx_d = wrap_idx(ins_q.dest_reg);

	brm_regfile #(.REG_COUNT(REG_COUNT)) u_rf (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr_a(idx_a), .raddr_b(idx_b), .rdata_a(va), .rdata_b(vb)
	);

	brm_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(va),
		.divisor(vb), .done(div_done), .quotient(quo), .remainder(rem)
	);

	// Clearing pass writes zero, otherwise write back the result.
	assign rf_we    = (state_q == ST_CLEAR) || (state_q == ST_WRITE && wr_q);
	assign rf_waddr = (state_q == ST_CLEAR) ? clr_q[AW-1:0] : idx_d;
	assign rf_wdata = (state_q == ST_CLEAR) ? 32'd0 : res_q;
	assign div_start = (state_q == ST_EXEC) && !stopped_q && vb != 32'd0 &&
		(ins_q.cmd == OP_DIV || ins_q.cmd == OP_MOD);

	// Counter update modulo the code size: advance by the length, wrap, then
	// add the offset of a taken jump (a negative one as code size minus magnitude)
	// and wrap again.
	always_comb begin
		pc_adv = 32'(pc_q) + 32'(op_len(ins_q.cmd));
		if (pc_adv >= 32'(CODE_BYTES))
			pc_adv = pc_adv - 32'(CODE_BYTES);
		pc_next = pc_adv;
		if (take_q)
			pc_next = pc_adv + (ins_q.jump_offset[7] ? 32'(CODE_BYTES) : 32'd0) +
				32'(signed'(ins_q.jump_offset));
		if (pc_next >= 32'(CODE_BYTES))
			pc_next = pc_next - 32'(CODE_BYTES);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == (AW+1)'(REG_COUNT - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_READ;
			ST_READ:  state_d = ST_EXEC;
			ST_EXEC:  state_d = div_start ? ST_DIV : ST_WRITE;
			ST_DIV:   if (div_done) state_d = ST_WRITE;
			ST_WRITE: state_d = ST_OUT;
			ST_OUT:   if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_stall = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pc_q        <= '0;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end
			if (state_q == ST_WRITE && !stopped_q) begin
				// advance by length, then the offset of a taken jump
				pc_q <= PW'(pc_next);
				if (op_halts(ins_q.cmd))
					stopped_q <= 1'b1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid)
			ins_q <= in_data;
		if (state_q == ST_EXEC) begin
			wr_q   <= 1'b0;
			take_q <= 1'b0;
			dz_q   <= 1'b0;
			pv_q   <= 1'b0;
			pval_q <= '0;
			res_q  <= '0;
			if (!stopped_q) begin
				case (ins_q.cmd)
					OP_ADD: begin res_q <= va + vb; wr_q <= 1'b1; end
					OP_SUB: begin res_q <= va - vb; wr_q <= 1'b1; end
					OP_MUL: begin res_q <= va * vb; wr_q <= 1'b1; end
					OP_DIV: begin
						res_q <= 32'hFFFF_FFFF; wr_q <= 1'b1; dz_q <= (vb == 32'd0);
					end
					OP_MOD: begin res_q <= va; wr_q <= 1'b1; dz_q <= (vb == 32'd0); end
					OP_JMP:  take_q <= 1'b1;
					OP_JEQ:  take_q <= (va == vb);
					OP_JNE:  take_q <= (va != vb);
					OP_JLT:  take_q <= (va < vb);
					OP_JLE:  take_q <= (va <= vb);
					OP_JGT:  take_q <= (va > vb);
					OP_JGE:  take_q <= (va >= vb);
					OP_JEQZ, OP_JLEZ: take_q <= (va == 32'd0);
					OP_JNEZ, OP_JGTZ: take_q <= (va != 32'd0);
					OP_JLTZ: take_q <= 1'b0;
					OP_JGEZ: take_q <= 1'b1;
					OP_IMM:  begin res_q <= ins_q.immediate; wr_q <= 1'b1; end
					OP_MOVE: begin res_q <= va; wr_q <= 1'b1; end
					OP_PRINT: begin pv_q <= 1'b1; pval_q <= va; end
					default: ;
				endcase
			end
		end
		if (state_q == ST_DIV && div_done)
			res_q <= (ins_q.cmd == OP_DIV) ? quo : rem;
		if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
			out_q.next_pc        <= 16'(pc_q);
			out_q.halted         <= stopped_q;
			out_q.print_valid    <= pv_q;
			out_q.print_value    <= pval_q;
			out_q.branch_taken   <= take_q;
			out_q.divide_by_zero <= dz_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	ap_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> in_stall)
		else $error("input accepted during clearing pass");
	ap_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("halt flag cleared");
	ap_div_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> state_q == ST_DIV)
		else $error("divider started outside division");
	ap_pv_no_branch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.print_valid |-> !out_data.branch_taken)
		else $error("print and branch in one result");
endmodule

// ----- rtl/brm_divider.sv -----
// Restoring unsigned 32-bit divider, one quotient bit per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
module brm_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient,
	output logic [31:0] remainder
);
	logic [31:0] quo_q, rem_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	// done pulses the cycle after the last step, with quotient and remainder settled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == 6'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

// ----- rtl/brm_regfile.sv -----
// Register file memory: one write port, two registered read ports.
// Depends on brm_pkg for the default depth.
`timescale 1ns / 1ps
module brm_regfile #(
	parameter int REG_COUNT = brm_pkg::REG_COUNT_DEF,
	localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [31:0]   rdata_a,
	output logic [31:0]   rdata_b
);
	logic [31:0] mem [REG_COUNT];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule
